### hw/rtl/ramt_pkg.sv
package ramt_pkg;

  localparam int POSITIONS   = 1024;
  localparam int VALUE_BITS  = 16;
  localparam int IDX_W       = 10;
  localparam int SIZE_W      = 11;
  localparam int NODE_W      = 11;
  localparam int NODES       = 2 * POSITIONS;
  localparam int STACK_DEPTH = 11;
  localparam int SP_W        = 4;
  localparam int CLR_W       = 12;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [SIZE_W-1:0]     size_t;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    node_t  rd_addr;
    logic   max_we;
    node_t  max_waddr;
    value_t max_wdata;
    logic   pend_we;
    node_t  pend_waddr;
    value_t pend_wdata;
  } mem_req_t;

  typedef struct packed {
    value_t max_q;
    value_t pend_q;
  } mem_rsp_t;

  typedef struct packed {
    node_t k;
    idx_t  l;
    idx_t  r;
    logic  ph;
  } frame_t;

endpackage

### hw/rtl/ramt_store.sv
module ramt_store (
  input  logic              clk,
  input  logic              rst,
  input  ramt_pkg::mem_req_t req,
  output ramt_pkg::mem_rsp_t rsp,
  output logic              busy
);
  import ramt_pkg::*;

  value_t             max_mem  [NODES];
  value_t             pend_mem [NODES];
  logic [CLR_W-1:0]   clr_idx;
  logic               max_we;
  logic               pend_we;
  node_t              max_wa;
  node_t              pend_wa;
  value_t             max_wd;
  value_t             pend_wd;

  // sweep every entry to zero after reset
  assign busy = ~clr_idx[CLR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_comb begin
    max_we  = busy | req.max_we;
    pend_we = busy | req.pend_we;
    max_wa  = busy ? clr_idx[NODE_W-1:0] : req.max_waddr;
    pend_wa = busy ? clr_idx[NODE_W-1:0] : req.pend_waddr;
    max_wd  = busy ? '0 : req.max_wdata;
    pend_wd = busy ? '0 : req.pend_wdata;
  end

  always_ff @(posedge clk) begin
    if (max_we) begin
      max_mem[max_wa] <= max_wd;
    end
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    rsp.max_q  <= max_mem[req.rd_addr];
    rsp.pend_q <= pend_mem[req.rd_addr];
  end

endmodule

### hw/rtl/ramt_walk.sv
module ramt_walk (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               kind,
  input  ramt_pkg::idx_t     range_low,
  input  ramt_pkg::idx_t     range_high,
  input  ramt_pkg::value_t   assign_value,
  input  ramt_pkg::size_t    eff_size,
  input  ramt_pkg::mem_rsp_t rsp,
  output ramt_pkg::mem_req_t req,
  output logic               idle,
  output logic               res_valid,
  output ramt_pkg::value_t   res_value,
  input  logic               res_take
);
  import ramt_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_ENTER = 13'h0002,
    S_PUSH  = 13'h0004,
    S_PL    = 13'h0008,
    S_PR    = 13'h0010,
    S_DEC   = 13'h0020,
    S_RET   = 13'h0040,
    S_RDL   = 13'h0080,
    S_RDR   = 13'h0100,
    S_CMB   = 13'h0200,
    S_DONE  = 13'h0400,
    S_SPARE = 13'h0800,
    S_HOLD  = 13'h1000
  } state_t;

  state_t          state;
  node_t           k;
  idx_t            l;
  idx_t            r;
  idx_t            st;
  idx_t            ed;
  value_t          v;
  logic            is_query;
  value_t          acc;
  value_t          mk;
  value_t          pv;
  value_t          lft;
  logic            cov;
  logic [SP_W-1:0] sp;
  frame_t          stack [STACK_DEPTH];

  frame_t          top;
  idx_t            mid;
  idx_t            top_mid;
  node_t           k_lo;
  node_t           k_hi;
  logic            disjoint;
  logic            covered;
  value_t          cmb_max;
  logic            start_ok;
  logic            q_empty;

  always_comb begin
    top      = stack[sp - 1'b1];
    mid      = l + ((r - l) >> 1);
    top_mid  = top.l + ((top.r - top.l) >> 1);
    k_lo     = {k[NODE_W-2:0], 1'b0};
    k_hi     = {k[NODE_W-2:0], 1'b1};
    disjoint = (st > r) || (ed < l);
    covered  = (st <= l) && (r <= ed);
    cmb_max  = (lft > rsp.max_q) ? lft : rsp.max_q;
    start_ok = (range_high >= range_low) && ({1'b0, range_high} < eff_size) &&
               (assign_value != '0);
    q_empty  = (range_high < range_low) || (eff_size == '0);
  end

  always_comb begin
    req = '0;
    req.rd_addr = k;
    case (state)
      S_PUSH: begin
        if (rsp.pend_q != '0) begin
          req.max_we     = 1'b1;
          req.max_waddr  = k;
          req.max_wdata  = rsp.pend_q;
          req.pend_we    = 1'b1;
          req.pend_waddr = k;
          req.pend_wdata = '0;
        end
      end
      S_PL: begin
        req.pend_we    = 1'b1;
        req.pend_waddr = k_lo;
        req.pend_wdata = pv;
      end
      S_PR: begin
        req.pend_we    = 1'b1;
        req.pend_waddr = k_hi;
        req.pend_wdata = pv;
      end
      S_DEC: begin
        if (!is_query && !disjoint && covered) begin
          req.max_we    = 1'b1;
          req.max_waddr = k;
          req.max_wdata = v;
        end
      end
      S_RDL: req.rd_addr = k_lo;
      S_RDR: req.rd_addr = k_hi;
      S_CMB: begin
        req.max_we    = 1'b1;
        req.max_waddr = k;
        req.max_wdata = cmb_max;
      end
      default: req.rd_addr = k;
    endcase
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_value = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            st       <= range_low;
            ed       <= range_high;
            v        <= assign_value;
            is_query <= kind;
            acc      <= '0;
            k        <= node_t'(1);
            l        <= '0;
            r        <= idx_t'(eff_size - 1'b1);
            sp       <= '0;
            if (kind == KIND_QUERY) begin
              state <= q_empty ? S_DONE : S_ENTER;
            end else if (start_ok) begin
              state <= S_ENTER;
            end
          end
        end
        S_ENTER: state <= S_PUSH;
        S_PUSH: begin
          mk  <= (rsp.pend_q != '0) ? rsp.pend_q : rsp.max_q;
          pv  <= rsp.pend_q;
          cov <= 1'b0;
          state <= ((rsp.pend_q != '0) && (l != r)) ? S_PL : S_DEC;
        end
        S_PL: state <= S_PR;
        S_PR: state <= cov ? S_RET : S_DEC;
        S_DEC: begin
          if (disjoint) begin
            state <= S_RET;
          end else if (covered) begin
            if (is_query) begin
              if (mk > acc) begin
                acc <= mk;
              end
              state <= S_RET;
            end else begin
              // hand the new value down to both children as pending
              pv    <= v;
              cov   <= 1'b1;
              state <= (l != r) ? S_PL : S_RET;
            end
          end else begin
            stack[sp] <= '{k: k, l: l, r: r, ph: 1'b0};
            sp        <= sp + 1'b1;
            k         <= k_lo;
            r         <= mid;
            state     <= S_ENTER;
          end
        end
        S_RET: begin
          if (sp == '0) begin
            state <= is_query ? S_DONE : S_IDLE;
          end else if (!top.ph) begin
            stack[sp - 1'b1].ph <= 1'b1;
            k     <= {top.k[NODE_W-2:0], 1'b1};
            l     <= top_mid + 1'b1;
            r     <= top.r;
            state <= S_ENTER;
          end else begin
            sp    <= sp - 1'b1;
            k     <= top.k;
            l     <= top.l;
            r     <= top.r;
            state <= is_query ? S_RET : S_RDL;
          end
        end
        S_RDL: state <= S_RDR;
        S_RDR: begin
          lft   <= rsp.max_q;
          state <= S_CMB;
        end
        S_CMB: state <= S_RET;
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/range_assign_max_table_top.sv
// Range-assign / range-maximum table over up to 1024 positions, kept as a
// lazy segment tree in two 2048-entry single-port-write memories (node
// maximum and pending assignment), both with a registered read.
// An assign beat (kind 0) writes assign_value to every position in
// [range_low, range_high] and yields no result; it is dropped when the range
// is reversed, runs past active_size, or the value is zero. A query beat
// (kind 1) yields one max_value beat: the largest stored value in the range,
// 0 for never-written positions or an empty range. One item is in the tree
// walker at a time: each visited node has read, push-down, two child pending
// write and decide steps plus one return step, the child writes skipped when
// nothing is pending, and each partly covered node on an assign adds steps
// to re-read and combine its children. A finished result sits in an output
// register, so the next item is taken while it waits. After reset the memories
// are swept to zero, during which in_stall stays high; active_size writes are
// taken at any time (cfg_ready is tied high) but should come only while idle.
module range_assign_max_table_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  ramt_pkg::size_t      active_size,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  ramt_pkg::idx_t       range_low,
  input  ramt_pkg::idx_t       range_high,
  input  ramt_pkg::value_t     assign_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ramt_pkg::value_t     max_value
);
  import ramt_pkg::*;

  size_t    size_reg;
  size_t    eff_size;
  mem_req_t req;
  mem_rsp_t rsp;
  logic     store_busy;
  logic     walk_idle;
  logic     res_valid;
  value_t   res_value;
  logic     res_take;
  logic     start;

  assign cfg_ready = 1'b1;

  // hold the size register; reset to the full table
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= size_t'(POSITIONS);
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= active_size;
    end
  end

  // saturate the size to the table depth
  assign eff_size = (size_reg > size_t'(POSITIONS)) ? size_t'(POSITIONS) : size_reg;

  // take a beat only when the walker is idle and the clearing sweep is done
  assign in_stall = ~walk_idle | store_busy;
  assign start    = in_valid & ~in_stall;

  // advance a result into the output register when it is empty or draining
  assign res_take = res_valid & (~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      max_value <= res_value;
    end
  end

  ramt_store u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .busy (store_busy)
  );

  ramt_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .range_low    (range_low),
    .range_high   (range_high),
    .assign_value (assign_value),
    .eff_size     (eff_size),
    .rsp          (rsp),
    .req          (req),
    .idle         (walk_idle),
    .res_valid    (res_valid),
    .res_value    (res_value),
    .res_take     (res_take)
  );

endmodule

### hw/rtl/ramt_checker.sv
module ramt_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             kind,
  input logic             out_valid,
  input logic             out_stall,
  input ramt_pkg::value_t max_value
);
  import ramt_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_value))
    else $error("result beat changed while stalled");

  // the clearing sweep blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing sweep");

  // an accepted query keeps the block busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (kind == KIND_QUERY) |=> in_stall)
    else $error("query accepted without walker going busy");

  // a new result appears only after the walker was busy
  a_res_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced from an idle walker");

endmodule

bind range_assign_max_table_top ramt_checker u_chk (.*);

### test/tb.sv
`timescale 1ns / 1ps

// Testbench for range_assign_max_table_top.
// Drive a mix of range assigns and range-maximum queries through the block while
// a lazy segment-tree predictor tracks the same tree shape. Check every
// max_value beat against the oldest predicted maximum.
module tb;
  import ramt_pkg::*;

  // Predictor of the lazy segment tree plus the queue of predicted maxima.
  class max_table_sb;
    typedef struct {
      int k;
      int l;
      int r;
      bit ph;
    } visit_t;

    value_t node_hi[NODES];
    value_t node_pend[NODES];
    int unsigned size_reg;
    value_t want_q[$];
    int n_assign;
    int n_query;

    function new();
      size_reg = 1024;
      foreach (node_hi[i]) begin
        node_hi[i] = '0;
        node_pend[i] = '0;
      end
    endfunction

    function int eff_size();
      return (size_reg > POSITIONS) ? POSITIONS : size_reg;
    endfunction

    function value_t rd_hi(int k);
      return (k < NODES) ? node_hi[k] : '0;
    endfunction

    function void wr_hi(int k, value_t v);
      if (k < NODES) node_hi[k] = v;
    endfunction

    function void wr_pend(int k, value_t v);
      if (k < NODES) node_pend[k] = v;
    endfunction

    function void push_pending(int k, int l, int r);
      value_t p;
      p = (k < NODES) ? node_pend[k] : '0;
      if (p != 0) begin
        wr_hi(k, p);
        if (l != r) begin
          wr_pend(2 * k, p);
          wr_pend(2 * k + 1, p);
        end
        wr_pend(k, '0);
      end
    endfunction

    // Walk the tree without recursion; left first, assigns combine on the way up.
    function value_t walk(bit is_query, int st, int ed, value_t v);
      visit_t stk[$];
      visit_t cur;
      value_t best;
      value_t a;
      value_t b;
      int mid;
      best = '0;
      stk.push_back('{1, 0, eff_size() - 1, 1'b0});
      while (stk.size() > 0) begin
        cur = stk.pop_back();
        if (cur.ph) begin
          a = rd_hi(2 * cur.k);
          b = rd_hi(2 * cur.k + 1);
          wr_hi(cur.k, (a > b) ? a : b);
        end else begin
          push_pending(cur.k, cur.l, cur.r);
          if (st > cur.r || ed < cur.l) continue;
          if (st <= cur.l && cur.r <= ed) begin
            if (is_query) begin
              if (rd_hi(cur.k) > best) best = rd_hi(cur.k);
            end else begin
              wr_hi(cur.k, v);
              if (cur.l != cur.r) begin
                wr_pend(2 * cur.k, v);
                wr_pend(2 * cur.k + 1, v);
              end
            end
            continue;
          end
          mid = cur.l + (cur.r - cur.l) / 2;
          if (!is_query) stk.push_back('{cur.k, cur.l, cur.r, 1'b1});
          stk.push_back('{2 * cur.k + 1, mid + 1, cur.r, 1'b0});
          stk.push_back('{2 * cur.k, cur.l, mid, 1'b0});
        end
      end
      return best;
    endfunction

    function void note_input(logic k, idx_t lo, idx_t hi, value_t v);
      int n;
      n = eff_size();
      if (k == KIND_ASSIGN) begin
        n_assign++;
        if (hi < lo || hi >= n || v == 0) return;
        void'(walk(1'b0, lo, hi, v));
      end else begin
        n_query++;
        if (hi < lo || n == 0) want_q.push_back('0);
        else want_q.push_back(walk(1'b1, lo, hi, '0));
      end
    endfunction

    // 0: match, 1: wrong value, 2: nothing was expected.
    function int check_result(value_t got, output value_t want);
      want = '0;
      if (want_q.size() == 0) return 2;
      want = want_q.pop_front();
      return (got === want) ? 0 : 1;
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  size_t  active_size = '0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   kind = KIND_ASSIGN;
  idx_t   range_low = '0;
  idx_t   range_high = '0;
  value_t assign_value = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  value_t max_value;

  max_table_sb sb = new();
  int errors = 0;
  int n_results = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  always #10 clk = ~clk;

  range_assign_max_table_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .active_size(active_size),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .range_low(range_low), .range_high(range_high), .assign_value(assign_value),
    .out_valid(out_valid), .out_stall(out_stall), .max_value(max_value)
  );

  task automatic report(string what, value_t got, value_t want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Result side: check each accepted beat, then pick the next stall value.
  always @(posedge clk) begin
    value_t want;
    int rc;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      rc = sb.check_result(max_value, want);
      if (rc == 2) report("unexpected max_value beat", max_value, want);
      else if (rc == 1) report("max_value", max_value, want);
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one beat after a random gap; hold it until the block takes it.
  task automatic send_item(logic k, idx_t lo, idx_t hi, value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    range_low <= lo;
    range_high <= hi;
    assign_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_input(k, lo, hi, v);
  endtask

  // Drain: wait for all predicted maxima, then let a trailing assign finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_size(size_t s);
    drain();
    cfg_valid <= 1'b1;
    active_size <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.size_reg = s;
  endtask

  // Random beat: mostly legal ranges inside the active size, some noise.
  task automatic send_random();
    int n;
    int sel;
    int lo;
    int hi;
    value_t v;
    n = sb.eff_size();
    sel = $urandom_range(99);
    v = (sel[0]) ? value_t'($urandom()) : value_t'($urandom_range(1, 300));
    if (n == 0 || sel < 12) begin
      lo = $urandom_range(1023);
      hi = $urandom_range(1023);
      if ($urandom_range(9) == 0) v = '0;
    end else begin
      lo = $urandom_range(n - 1);
      if ($urandom_range(3) == 0) hi = lo + $urandom_range(3);
      else hi = $urandom_range(n - 1);
      if (hi >= n) hi = n - 1;
      if (hi < lo) begin
        sel = lo;
        lo = hi;
        hi = sel;
      end
    end
    send_item($urandom_range(1) ? KIND_QUERY : KIND_ASSIGN, idx_t'(lo), idx_t'(hi), v);
  endtask

  task automatic random_run(int count);
    repeat (count) send_random();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Hold off until the clearing sweep ends.
    do @(posedge clk); while (in_stall);

    // Directed: empty table, full-range writes, extremes, ignored assigns.
    write_size(11'd1024);
    send_item(KIND_QUERY, 10'd0, 10'd1023, '0);
    send_item(KIND_ASSIGN, 10'd0, 10'd1023, 16'hFFFF);
    send_item(KIND_QUERY, 10'd1023, 10'd1023, '0);
    send_item(KIND_ASSIGN, 10'd5, 10'd5, 16'd1);
    send_item(KIND_QUERY, 10'd5, 10'd5, '0);
    send_item(KIND_QUERY, 10'd4, 10'd6, '0);
    send_item(KIND_ASSIGN, 10'd0, 10'd1023, 16'h5555);
    send_item(KIND_ASSIGN, 10'd300, 10'd200, 16'hAAAA);
    send_item(KIND_ASSIGN, 10'd3, 10'd700, 16'd0);
    send_item(KIND_QUERY, 10'd0, 10'd1023, '0);
    send_item(KIND_QUERY, 10'd9, 10'd8, '0);
    send_item(KIND_ASSIGN, 10'd512, 10'd513, 16'hAAAA);
    send_item(KIND_QUERY, 10'd0, 10'd511, '0);
    send_item(KIND_QUERY, 10'd513, 10'd1023, '0);

    // Past the end, then reinterpret the tree under other shapes.
    write_size(11'd37);
    send_item(KIND_ASSIGN, 10'd30, 10'd37, 16'h1234);
    send_item(KIND_QUERY, 10'd0, 10'd1023, '0);
    send_item(KIND_QUERY, 10'd36, 10'd900, '0);
    write_size(11'd0);
    send_item(KIND_ASSIGN, 10'd0, 10'd0, 16'd7);
    send_item(KIND_QUERY, 10'd0, 10'd0, '0);
    write_size(11'd2047);
    send_item(KIND_QUERY, 10'd0, 10'd1023, '0);
    write_size(11'd1);
    send_item(KIND_ASSIGN, 10'd0, 10'd0, 16'd9);
    send_item(KIND_QUERY, 10'd0, 10'd1023, '0);

    // Random phases across sizes and idling profiles.
    send_idle_pct = 29;
    recv_idle_pct = 62;
    write_size(11'd1000);
    random_run(160);
    write_size(11'd1024);
    random_run(160);
    send_idle_pct = 62;
    recv_idle_pct = 29;
    write_size(11'd37);
    random_run(160);
    write_size(11'd2047);
    random_run(160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(11'd1);
    random_run(60);
    write_size(11'd777);
    // Back pressure: receiver holds off while queries keep coming.
    hold_off = 600;
    random_run(90);
    write_size(11'd1024);
    random_run(160);

    drain();
    $display("Covered %0d assign and %0d query beats, %0d results checked,",
             sb.n_assign, sb.n_query, n_results);
    $display("over table sizes 0, 1, 37, 777, 1000, 1024 and saturated 2047.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
